>>> src/rlp_stream_encoder_assert.svh
// Assertion macros for the RLP stream encoder.
// No dependencies. Each user supplies aclk and aresetn in its scope.
`ifndef RLP_STREAM_ENCODER_ASSERT_SVH
`define RLP_STREAM_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define RLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define RLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rlp_pkg.sv
// Shared types, opcodes and helpers for the RLP stream encoder.
// No dependencies.
package rlp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned WORD_BYTES = WORD_W / BYTE_W;
    localparam int unsigned BUF_BYTES  = WORD_BYTES + 1;
    localparam int unsigned CNT_W    = $clog2(BUF_BYTES + 1);

    localparam logic [BYTE_W-1:0] STR_BASE    = 8'h80;
    localparam logic [BYTE_W-1:0] LIST_BASE   = 8'hC0;
    localparam logic [BYTE_W-1:0] SHORT_LIMIT = 8'd55;

    typedef enum logic [1:0] {
        OP_STR_HDR  = 2'd0,
        OP_DATA     = 2'd1,
        OP_INT      = 2'd2,
        OP_LIST_HDR = 2'd3
    } rlp_op_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic shift;
    } rlp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic final_byte;
        logic load_emits;
    } rlp_status_t;

    // Bytes needed for v without leading zeros; 0 for v == 0.
    function automatic logic [CNT_W-1:0] byte_count(input logic [WORD_W-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BYTES; i++) begin
            if (v[i*BYTE_W +: BYTE_W] != '0) begin
                n = CNT_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

>>> src/rlp_ctrl.sv
// Handshake controller for the RLP stream encoder.
// Depends on rlp_pkg.
module rlp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  rlp_pkg::rlp_status_t status,
    output rlp_pkg::rlp_cmd_t    cmd
);
    import rlp_pkg::*;

    typedef enum logic {
        ST_EMPTY,
        ST_SEND
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        m_valid   = (state_reg == ST_SEND);
        s_ready   = (state_reg == ST_EMPTY) || (status.final_byte && m_ready);
        cmd.load  = s_valid && s_ready;
        cmd.shift = m_valid && m_ready;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_EMPTY: begin
                if (cmd.load && status.load_emits) begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (cmd.shift && status.final_byte) begin
                    state_next = (cmd.load && status.load_emits) ? ST_SEND : ST_EMPTY;
                end
            end
            default: state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/rlp_dp.sv
// Datapath for the RLP stream encoder: header build, output byte buffer,
// open-string state. Depends on rlp_pkg.
module rlp_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rlp_pkg::rlp_cmd_t         cmd,
    output rlp_pkg::rlp_status_t      status,
    input  logic [1:0]                s_opcode,
    input  logic [rlp_pkg::WORD_W-1:0] s_length,
    input  logic [rlp_pkg::WORD_W-1:0] s_number,
    input  logic [rlp_pkg::BYTE_W-1:0] s_data_byte,
    output logic [rlp_pkg::BYTE_W-1:0] m_out_byte,
    output logic                      m_last,
    output logic                      m_fault
);
    import rlp_pkg::*;

    localparam int unsigned BUF_W = BUF_BYTES * BYTE_W;

    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              fault_reg, fault_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic              single_reg, single_next;

    logic [WORD_W-1:0] value;
    logic [CNT_W-1:0]  nbytes;
    logic [5:0]        be_shift;
    logic [WORD_W-1:0] be_bytes;
    logic [BYTE_W-1:0] hdr_base;
    logic [BUF_W-1:0]  ld_buf;
    logic [CNT_W-1:0]  ld_cnt;
    logic              ld_fault;

    always_comb begin
        value    = (rlp_op_t'(s_opcode) == OP_INT) ? s_number : s_length;
        nbytes   = byte_count(value);
        // Left-align the significant bytes of value.
        be_shift = {3'(CNT_W'(WORD_BYTES) - nbytes), 3'b000};
        be_bytes = value << be_shift;
        hdr_base = (rlp_op_t'(s_opcode) == OP_LIST_HDR) ? LIST_BASE : STR_BASE;

        ld_buf      = '0;
        ld_cnt      = '0;
        ld_fault    = 1'b0;
        rem_next    = rem_reg;
        single_next = single_reg;

        case (rlp_op_t'(s_opcode))
            OP_STR_HDR, OP_LIST_HDR: begin
                if (value <= WORD_W'(SHORT_LIMIT)) begin
                    ld_buf[BUF_W-1 -: BYTE_W] = hdr_base + value[BYTE_W-1:0];
                    ld_cnt = CNT_W'(1);
                end else begin
                    ld_buf = {hdr_base + SHORT_LIMIT + BYTE_W'(nbytes), be_bytes};
                    ld_cnt = nbytes + CNT_W'(1);
                end
                if (rlp_op_t'(s_opcode) == OP_STR_HDR) begin
                    rem_next    = s_length;
                    single_next = (s_length == WORD_W'(1));
                    // Defer the one-byte header until its data arrives.
                    if (single_next) begin
                        ld_cnt = '0;
                    end
                end
            end
            OP_DATA: begin
                if (rem_reg == '0) begin
                    ld_cnt   = CNT_W'(1);
                    ld_fault = 1'b1;
                end else begin
                    if (single_reg && s_data_byte >= STR_BASE) begin
                        ld_buf[BUF_W-1 -: 2*BYTE_W] = {STR_BASE + BYTE_W'(1), s_data_byte};
                        ld_cnt = CNT_W'(2);
                    end else begin
                        ld_buf[BUF_W-1 -: BYTE_W] = s_data_byte;
                        ld_cnt = CNT_W'(1);
                    end
                    single_next = 1'b0;
                    rem_next    = rem_reg - WORD_W'(1);
                end
            end
            OP_INT: begin
                if (s_number == '0) begin
                    ld_buf[BUF_W-1 -: BYTE_W] = STR_BASE;
                    ld_cnt = CNT_W'(1);
                end else if (s_number < WORD_W'(STR_BASE)) begin
                    ld_buf[BUF_W-1 -: BYTE_W] = s_number[BYTE_W-1:0];
                    ld_cnt = CNT_W'(1);
                end else begin
                    ld_buf = {STR_BASE + BYTE_W'(nbytes), be_bytes};
                    ld_cnt = nbytes + CNT_W'(1);
                end
            end
            default: begin
                ld_cnt = '0;
            end
        endcase

        status.load_emits = (ld_cnt != '0);
        status.final_byte = (cnt_reg == CNT_W'(1));

        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        fault_next = fault_reg;
        if (cmd.load) begin
            buf_next   = ld_buf;
            cnt_next   = ld_cnt;
            fault_next = ld_fault;
        end else if (cmd.shift) begin
            buf_next = buf_reg << BYTE_W;
            cnt_next = cnt_reg - CNT_W'(1);
        end

        m_out_byte = buf_reg[BUF_W-1 -: BYTE_W];
        m_last     = status.final_byte;
        m_fault    = fault_reg;
    end

    always_ff @(posedge aclk) begin
        buf_reg   <= buf_next;
        fault_reg <= fault_next;
        if (!aresetn) begin
            cnt_reg    <= '0;
            rem_reg    <= '0;
            single_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (cmd.load) begin
                rem_reg    <= rem_next;
                single_reg <= single_next;
            end
        end
    end

endmodule

>>> src/rlp_stream_encoder.sv
// RLP stream encoder top level. The first byte of a request is valid in the
// cycle after acceptance. A request emitting k bytes (0..9) holds the output
// buffer until they leave; the next request is taken in the cycle the final
// byte leaves, so payload bytes sustain one per cycle while m_ready stays high.
// Reset (aresetn low, synchronous) empties the buffer and closes any string.
module rlp_stream_encoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_opcode,
    input  logic [rlp_pkg::WORD_W-1:0]  s_length,
    input  logic [rlp_pkg::WORD_W-1:0]  s_number,
    input  logic [rlp_pkg::BYTE_W-1:0]  s_data_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rlp_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                        m_last,
    output logic                        m_fault
);
    import rlp_pkg::*;

`include "rlp_stream_encoder_assert.svh"

    rlp_cmd_t    cmd;
    rlp_status_t status;

    // Controller owns the handshakes; it loads a new request only when the
    // buffer is empty or its final byte is leaving this cycle.
    rlp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath builds header and payload bytes into a shift buffer and
    // tracks the open string (bytes remaining, deferred one-byte header).
    rlp_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_opcode    (s_opcode),
        .s_length    (s_length),
        .s_number    (s_number),
        .s_data_byte (s_data_byte),
        .m_out_byte  (m_out_byte),
        .m_last      (m_last),
        .m_fault     (m_fault)
    );

    // A new request may only enter behind the final byte of the previous one.
    `RLP_ASSERT_NOW(a_ready_only_at_last, m_valid && s_ready, m_last, "request taken mid-result")
    // Fault results are always single bytes.
    `RLP_ASSERT_NOW(a_fault_is_last, m_valid && m_fault, m_last, "fault on non-final byte")
    // After a non-final byte leaves, another byte must follow.
    `RLP_ASSERT_NEXT(a_more_follows, m_valid && m_ready && !m_last, m_valid, "result truncated")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for rlp_stream_encoder: a scoreboard class predicts
// the encoded byte stream of every request. Depends on rlp_pkg and the top level.

module tb_top;
    import rlp_pkg::*;

    localparam int unsigned TOTAL_REQUESTS = 420;
    localparam int unsigned IDLE_PCT       = 37;
    // Nothing accepted for this many cycles means the block hung.
    localparam int unsigned QUIET_LIMIT    = 2000;
    // Covers the longest header (nine bytes), with margin.
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned PRINT_CAP      = 200;

    // One expected output beat.
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
        logic              fault;
    } enc_byte_t;

    // Encoder state mirror plus the queue of bytes still to come out.
    class rlp_byte_scoreboard;
        enc_byte_t         expected_bytes[$];
        enc_byte_t         req_bytes[$];
        logic [WORD_W-1:0] open_remaining;
        logic              single_deferred;
        int unsigned       mismatches;
        int unsigned       printed;

        function new();
            open_remaining  = '0;
            single_deferred = 1'b0;
            mismatches      = 0;
            printed         = 0;
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        // Significant bytes of v once leading zero bytes are stripped.
        function int unsigned sig_bytes(logic [WORD_W-1:0] v);
            int unsigned n;
            n = 0;
            while (v != '0) begin
                v = v >> BYTE_W;
                n++;
            end
            return n;
        endfunction

        function void emit(logic [BYTE_W-1:0] v, logic is_fault);
            enc_byte_t b;
            b.value = v;
            b.last  = is_fault;
            b.fault = is_fault;
            req_bytes = {req_bytes, b};
        endfunction

        // Append n big-endian bytes of v.
        function void emit_be(logic [WORD_W-1:0] v, int unsigned n);
            logic [WORD_W-1:0] sh;
            for (int i = n; i > 0; i--) begin
                sh = v >> (BYTE_W * (i - 1));
                emit(sh[BYTE_W-1:0], 1'b0);
            end
        endfunction

        // Short form up to 55 bytes, else long form with the length bytes.
        function void emit_length(logic [BYTE_W-1:0] base, logic [WORD_W-1:0] len);
            int unsigned n;
            if (len <= WORD_W'(SHORT_LIMIT)) begin
                emit(base + len[BYTE_W-1:0], 1'b0);
            end else begin
                n = sig_bytes(len);
                emit(base + SHORT_LIMIT + BYTE_W'(n), 1'b0);
                emit_be(len, n);
            end
        endfunction

        // Predict the bytes of one accepted request and queue them.
        function void note_request(rlp_op_t op, logic [WORD_W-1:0] len,
                                   logic [WORD_W-1:0] num, logic [BYTE_W-1:0] data);
            int unsigned n;
            req_bytes.delete();
            case (op)
                OP_STR_HDR: begin
                    // A new header drops whatever the open string still owed.
                    open_remaining  = len;
                    single_deferred = (len == 1);
                    if (len != 1) begin
                        emit_length(STR_BASE, len);
                    end
                end
                OP_DATA: begin
                    if (open_remaining == '0) begin
                        emit('0, 1'b1);
                    end else begin
                        if (single_deferred && data >= STR_BASE) begin
                            emit(STR_BASE + 8'd1, 1'b0);
                        end
                        single_deferred = 1'b0;
                        open_remaining  = open_remaining - 1;
                        emit(data, 1'b0);
                    end
                end
                OP_INT: begin
                    n = sig_bytes(num);
                    if (num == '0) begin
                        emit(STR_BASE, 1'b0);
                    end else if (num < WORD_W'(STR_BASE)) begin
                        emit(num[BYTE_W-1:0], 1'b0);
                    end else begin
                        emit(STR_BASE + BYTE_W'(n), 1'b0);
                        emit_be(num, n);
                    end
                end
                default: begin
                    emit_length(LIST_BASE, len);
                end
            endcase
            if (req_bytes.size() != 0) begin
                req_bytes[req_bytes.size()-1].last = 1'b1;
            end
            expected_bytes = {expected_bytes, req_bytes};
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            // Count every mismatch but keep the log readable.
            if (printed < PRINT_CAP) begin
                printed++;
                $display("%0t ERROR: %s", $time, msg);
            end
        endtask

        task check_byte(logic [BYTE_W-1:0] value, logic last, logic fault);
            enc_byte_t want;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %b fault %b",
                                          value, last, fault));
            end else begin
                want = expected_bytes.pop_front();
                if (value !== want.value) begin
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              value, want.value));
                end
                if (last !== want.last) begin
                    report_mismatch($sformatf("last %b on byte %02h, expected %b",
                                              last, want.value, want.last));
                end
                if (fault !== want.fault) begin
                    report_mismatch($sformatf("fault %b on byte %02h, expected %b",
                                              fault, want.value, want.fault));
                end
            end
        endtask
    endclass

    logic                aclk;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [1:0]          s_opcode    = '0;
    logic [WORD_W-1:0]   s_length    = '0;
    logic [WORD_W-1:0]   s_number    = '0;
    logic [BYTE_W-1:0]   s_data_byte = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [BYTE_W-1:0]   m_out_byte;
    logic                m_last;
    logic                m_fault;

    rlp_byte_scoreboard  sb;
    int unsigned         n_sent       = 0;
    int unsigned         quiet_cycles = 0;
    int unsigned         s_idle_pct   = IDLE_PCT;
    int unsigned         m_idle_pct   = IDLE_PCT;

    rlp_stream_encoder u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_length    (s_length),
        .s_number    (s_number),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last      (m_last),
        .m_fault     (m_fault)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Receiver: stall at random; m_idle_pct drops to zero for the burst stretch.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    // Monitor: note the request first, then check the byte leaving this edge.
    // A request accepted here cannot produce a byte before the next edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_request(rlp_op_t'(s_opcode), s_length, s_number, s_data_byte);
            end
            if (m_valid && m_ready) begin
                sb.check_byte(m_out_byte, m_last, m_fault);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Watchdog: give up when no request and no byte has moved for too long.
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("rlp_stream_encoder verification failed");
        $finish;
    end

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random value confined to the low nbytes bytes.
    function automatic logic [WORD_W-1:0] rand_wide(int unsigned nbytes);
        logic [WORD_W-1:0] v;
        v = rand64();
        if (nbytes == 0) begin
            v = '0;
        end else if (nbytes < WORD_BYTES) begin
            v = v & ((64'd1 << (BYTE_W * nbytes)) - 1);
        end
        return v;
    endfunction

    // Present one request, idling first at random; hold it until accepted.
    task automatic send_request(rlp_op_t op, logic [WORD_W-1:0] len,
                                logic [WORD_W-1:0] num, logic [BYTE_W-1:0] data);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_length    <= len;
        s_number    <= num;
        s_data_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    // Fields an opcode ignores still carry random values.
    task automatic send_str(logic [WORD_W-1:0] len);
        send_request(OP_STR_HDR, len, rand64(), BYTE_W'($urandom));
    endtask

    task automatic send_data(logic [BYTE_W-1:0] data);
        send_request(OP_DATA, rand64(), rand64(), data);
    endtask

    task automatic send_int(logic [WORD_W-1:0] num);
        send_request(OP_INT, rand64(), num, BYTE_W'($urandom));
    endtask

    task automatic send_list(logic [WORD_W-1:0] len);
        send_request(OP_LIST_HDR, len, rand64(), BYTE_W'($urandom));
    endtask

    // Wait until every predicted byte has come out; the caller drops valid.
    task automatic wait_for_drain();
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Mostly short lengths, sometimes around the 55-byte boundary, rarely huge.
    function automatic logic [WORD_W-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return WORD_W'($urandom_range(0, 6));
        end else if (r < 85) begin
            return WORD_W'($urandom_range(50, 60));
        end else begin
            return rand_wide($urandom_range(1, 8));
        end
    endfunction

    // One string: header then its payload, sometimes cut short or overrun.
    task automatic send_string_seq();
        logic [WORD_W-1:0] len;
        int unsigned       ndata;
        int unsigned       r;
        logic [BYTE_W-1:0] d;
        len = ($urandom_range(0, 9) == 0) ? 64'd1 : pick_length();
        ndata = (len > 64'd60) ? $urandom_range(0, 4) : int'(len);
        r = $urandom_range(0, 99);
        if (r < 10 && ndata > 0) begin
            // Leave it open; the next header abandons the rest.
            ndata = $urandom_range(0, ndata - 1);
        end else if (r < 18) begin
            // Overrun: for lengths up to 60 the extra byte finds no string open.
            ndata = ndata + 1;
        end
        send_str(len);
        for (int i = 0; i < ndata; i++) begin
            d = BYTE_W'($urandom);
            if (len == 1 && $urandom_range(0, 1) == 0) begin
                d = d & 8'h7F;
            end
            send_data(d);
        end
    endtask

    initial begin
        int unsigned r;
        bit          paused;
        paused = 1'b0;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: headers at the boundaries, one-byte strings both ways,
        // stray data, integers at the boundaries, list headers, overlaps.
        send_str(64'd0);
        send_str(64'd1);
        send_data(8'h00);
        send_str(64'd1);
        send_data(8'hFF);
        send_str(64'd1);
        send_data(8'h7F);
        send_data(8'h80);
        send_str(64'd55);
        send_str(64'd56);
        send_data(8'hA5);
        send_str(64'd256);
        send_str(64'hFFFF_FFFF_FFFF_FFFF);
        send_data(8'h00);
        // Integers and list headers while a string is left open.
        send_int(64'd0);
        send_int(64'd1);
        send_int(64'h7F);
        send_int(64'h80);
        send_int(64'hFFFF_FFFF_FFFF_FFFF);
        send_list(64'd0);
        send_list(64'd55);
        send_list(64'd56);
        send_list(64'hFFFF_FFFF_FFFF_FFFF);
        // Deferred one-byte header dropped by the next header.
        send_str(64'd1);
        send_str(64'd0);
        send_data(8'h80);

        // Hold off until the directed requests are fully answered.
        s_valid <= 1'b0;
        wait_for_drain();

        while (n_sent < TOTAL_REQUESTS) begin
            // Run a burst with no idling on either side.
            if (n_sent >= 180 && n_sent < 260) begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end else begin
                s_idle_pct = IDLE_PCT;
                m_idle_pct = IDLE_PCT;
            end
            if (!paused && n_sent >= 300) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                wait_for_drain();
            end
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_string_seq();
            end else if (r < 63) begin
                send_int(rand_wide($urandom_range(0, 8)));
            end else if (r < 78) begin
                send_list(($urandom_range(0, 3) == 0) ? rand64() : pick_length());
            end else if (r < 88) begin
                send_data(BYTE_W'($urandom));
            end else begin
                // Integer and list header interleaved with an open string.
                send_str(WORD_W'($urandom_range(3, 6)));
                send_data(BYTE_W'($urandom));
                send_int(rand_wide($urandom_range(0, 8)));
                send_data(BYTE_W'($urandom));
                send_list(pick_length());
                send_data(BYTE_W'($urandom));
            end
        end

        // Drop valid, drain, then watch a little longer for stray bytes.
        s_valid <= 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.report_mismatch($sformatf("%0d bytes never came out", sb.pending()));
        end
        if (sb.mismatches == 0) begin
            $display("rlp_stream_encoder verification clean");
        end else begin
            $display("rlp_stream_encoder verification failed");
        end
        $finish;
    end

endmodule
